/* design/assert_macros.svh */
// Assertion macros for the RTL files (included by lpfe_queue).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that stays live during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/lpfe_pkg.sv */
// Shared types and constants for the length-prefixed frame extractor.
`default_nettype none

package lpfe_pkg;

    localparam logic [7:0]  START_FLAG  = 8'h7E;
    localparam logic [7:0]  END_FLAG    = 8'hCE;
    localparam logic [15:0] LIMIT_RESET = 16'd1024;

    // configuration register indexes
    localparam logic CFG_FORMAT = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    // frame_format values
    localparam logic FMT_WHOLE   = 1'b0;
    localparam logic FMT_PAYLOAD = 1'b1;

    // frame status codes
    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_BAD_END = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    // result queue between parser and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       frame_end;
        logic [1:0] frame_status;
    } lpfe_result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lpfe_q_stat_t;

endpackage

`default_nettype wire

/* design/length_prefixed_frame_extractor.sv */
// Top level of the length-prefixed, flag-delimited frame extractor.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata = rx_byte
//  m_*       out  m_tvalid/m_tready    m_tdata = data, m_tlast = frame_end,
//                                      m_tuser = {frame_status, has_data}
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index 0 frame_format, 1 length_limit
//
// One byte per cycle while the result queue is not full; the phase machine decides
// each byte combinationally. Results reach m_tdata via the queue and output register.
// s_tready drops only when the four-entry result queue is full; m_tready stalls
// the output register, so the queue can fill. cfg_ready is always high.
// rst_n resets the phase machine, queue pointers, output valid and parser registers.
`default_nettype none

module length_prefixed_frame_extractor
    import lpfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data
    output logic             m_tlast,
    output logic [2:0]       m_tuser,   // [0] has_data, [2:1] frame_status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    lpfe_q_stat_t q_stat;
    lpfe_result_t push_data;
    lpfe_result_t head;
    logic         push;
    logic         pop;

    lpfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    lpfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    lpfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* design/lpfe_front.sv */
// Byte parser: hunts for the start flag, reads the length, classifies frame bytes.
`default_nettype none

module lpfe_front
    import lpfe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire lpfe_q_stat_t q_stat,
    output logic              push,
    output lpfe_result_t      push_data
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN1,
        PH_LEN2,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic        format_reg;
    logic [15:0] limit_reg;

    logic        accept;
    logic        emit;
    logic [15:0] len_n;
    logic        whole;

    assign s_tready  = !q_stat.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign whole     = (format_reg == FMT_WHOLE);
    assign len_n     = {length_high_reg, s_tdata};

    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        length_high_next = length_high_reg;
        emit             = 1'b0;
        push_data        = '0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (s_tdata == START_FLAG)
                begin
                    phase_next = PH_LEN1;
                    if (whole)
                    begin
                        emit               = 1'b1;
                        push_data.data     = s_tdata;
                        push_data.has_data = 1'b1;
                    end
                end
            end
            PH_LEN1:
            begin
                if (whole)
                begin
                    emit               = 1'b1;
                    push_data.data     = s_tdata;
                    push_data.has_data = 1'b1;
                    if (s_tdata == 8'd0 || s_tdata >= 8'd254)
                    begin
                        phase_next             = PH_HUNT;
                        bytes_left_next        = '0;
                        push_data.frame_end    = 1'b1;
                        push_data.frame_status = STATUS_BAD_LEN;
                    end
                    else
                    begin
                        phase_next      = PH_BODY;
                        bytes_left_next = {8'd0, s_tdata};
                    end
                end
                else
                begin
                    length_high_next = s_tdata;
                    phase_next       = PH_LEN2;
                end
            end
            PH_LEN2:
            begin
                // always two-byte rules here, whatever the format now says
                if (len_n == 16'd0 || len_n > limit_reg)
                begin
                    phase_next             = PH_HUNT;
                    bytes_left_next        = '0;
                    emit                   = 1'b1;
                    push_data.frame_end    = 1'b1;
                    push_data.frame_status = STATUS_BAD_LEN;
                end
                else
                begin
                    phase_next      = PH_BODY;
                    bytes_left_next = len_n;
                end
            end
            PH_BODY:
            begin
                emit = 1'b1;
                if (bytes_left_reg <= 16'd1)
                begin
                    phase_next             = PH_HUNT;
                    bytes_left_next        = '0;
                    push_data.frame_end    = 1'b1;
                    push_data.frame_status = (s_tdata == END_FLAG) ? STATUS_GOOD
                                                                   : STATUS_BAD_END;
                    if (whole)
                    begin
                        push_data.data     = s_tdata;
                        push_data.has_data = 1'b1;
                    end
                end
                else
                begin
                    bytes_left_next    = bytes_left_reg - 16'd1;
                    push_data.data     = s_tdata;
                    push_data.has_data = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            bytes_left_reg  <= '0;
            length_high_reg <= '0;
            format_reg      <= FMT_WHOLE;
            limit_reg       <= LIMIT_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                bytes_left_reg  <= bytes_left_next;
                length_high_reg <= length_high_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FORMAT: format_reg <= cfg_data[0];
                    CFG_LIMIT:  limit_reg  <= cfg_data;
                    default:    format_reg <= format_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* design/lpfe_queue.sv */
// Short result queue decoupling the parser from the output stage.
`default_nettype none

module lpfe_queue
    import lpfe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire lpfe_result_t push_data,
    input  wire logic         pop,
    output lpfe_result_t      head,
    output lpfe_q_stat_t      q_stat
);

`include "assert_macros.svh"

    lpfe_result_t         entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `ASSERT_CLK(a_count_in_range, count_reg <= Q_CNT_W'(Q_DEPTH), "queue count overflow")
    `ASSERT_CLK(a_no_push_full, q_stat.full |-> !push, "push into full queue")
    `ASSERT_CLK(a_no_pop_empty, q_stat.empty |-> !pop, "pop from empty queue")
    `ASSERT_CLK(a_ptr_gap, (Q_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[Q_PTR_W-1:0]),
        "queue pointers disagree with count")

endmodule

`default_nettype wire

/* design/lpfe_back.sv */
// Output stage: moves queued results into the registered output channel.
`default_nettype none

module lpfe_back
    import lpfe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire lpfe_q_stat_t q_stat,
    input  wire lpfe_result_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [2:0]        m_tuser
);

    logic         m_tvalid_reg;
    lpfe_result_t out_reg;

    // load whenever the queue holds a result and the slot is free or being taken this cycle
    assign pop = !q_stat.empty && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (pop)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= head;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = {out_reg.frame_status, out_reg.has_data};

endmodule

`default_nettype wire
